/* sv/crpt_pkg.sv */
package crpt_pkg;

    // Fraction bits kept below the integer part of the running average.
    localparam int AVG_FRAC_BITS = 16;

    // Entries in the queue between the front and the averaging back end.
    localparam int QUEUE_DEPTH = 4;

    // Register port geometry.
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;

    // Register indexes.
    localparam logic REG_SMOOTHING_GAIN = 1'b0;

    // Reset value of the smoothing gain.
    localparam int GAIN_RESET = 7;

    typedef logic [PADDR_W-1:0] t_paddr;
    typedef logic [PDATA_W-1:0] t_pdata;

endpackage

/* sv/crpt_front.sv */
module crpt_front #(
    parameter int SB = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic signed [SB-1:0] i_re,
    input  logic signed [SB-1:0] i_im,
    output logic                o_pow_valid,
    input  logic                i_pow_ready,
    output logic [2*SB-1:0]     o_pow
);
    localparam int PW = 2 * SB;

    logic                 r_valid;
    logic signed [SB-1:0] r_re;
    logic signed [SB-1:0] r_im;
    logic signed [PW-1:0] w_sq_re;
    logic signed [PW-1:0] w_sq_im;

    assign o_full      = r_valid && !i_pow_ready;
    assign o_pow_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_full) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_re <= i_re;
            r_im <= i_im;
        end
    end

    // Each square is nonnegative and at most 2^(2*SB-2), so the sum fits PW bits.
    assign w_sq_re = PW'(r_re) * PW'(r_re);
    assign w_sq_im = PW'(r_im) * PW'(r_im);
    assign o_pow   = $unsigned(w_sq_re) + $unsigned(w_sq_im);

endmodule

/* sv/crpt_queue.sv */
module crpt_queue #(
    parameter int W     = 32,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr_valid,
    output logic         o_wr_ready,
    input  logic [W-1:0] i_wr_data,
    output logic         o_rd_valid,
    input  logic         i_rd_ready,
    output logic [W-1:0] o_rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_wr_ready = (r_count != FULL_CNT);
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = i_rd_ready && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* sv/crpt_avg.sv */
module crpt_avg #(
    parameter int SB = 16,
    parameter int G  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic [G:0]      i_gain,
    input  logic            i_pow_valid,
    output logic            o_pow_ready,
    input  logic [2*SB-1:0] i_pow,
    output logic            o_hand_valid,
    input  logic            i_hand_ready,
    output logic [2*SB-1:0] o_hand_data
);
    import crpt_pkg::*;

    localparam int PW     = 2 * SB;
    localparam int AVG_W  = PW + AVG_FRAC_BITS;
    localparam int DW     = AVG_W + 1;
    localparam int LO_W   = DW / 2;
    localparam int HI_W   = DW - LO_W;
    localparam int GW     = G + 1;
    localparam int PLO_W  = LO_W + GW;
    localparam int PHI_W  = HI_W + GW + 1;
    localparam int PROD_W = DW + GW;
    localparam int SUM_W  = AVG_W + 2;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_HAND = 3'd4;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [AVG_W-1:0]         r_avg;
    logic [DW-1:0]            r_diff;
    logic [PLO_W-1:0]         r_plo;
    logic signed [PHI_W-1:0]  r_phi;
    logic signed [PROD_W-1:0] r_prod;
    logic [DW-1:0]            w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_step;
    logic [SUM_W-1:0]         w_sum;

    assign o_pow_ready  = (r_state == ST_IDLE);
    assign o_hand_valid = (r_state == ST_HAND);
    assign o_hand_data  = r_avg[AVG_W-1:AVG_FRAC_BITS];

    // The update avg + floor(g * (target - avg) / 2^G) equals the weighted form.
    assign w_diff = {1'b0, i_pow, {AVG_FRAC_BITS{1'b0}}} - {1'b0, r_avg};

    assign w_prod = (PROD_W'(r_phi) <<< LO_W) + $signed({{HI_W{1'b0}}, r_plo});
    assign w_step = r_prod >>> G;
    assign w_sum  = {2'b00, r_avg} + w_step[SUM_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_pow_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_HAND;
            ST_HAND: begin
                if (i_hand_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_avg   <= '0;
        end else begin
            r_state <= n_state;
            if (i_clear) begin
                r_avg <= '0;
            end else if (r_state == ST_UPD) begin
                r_avg <= w_sum[AVG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_pow_valid) begin
            r_diff <= w_diff;
        end
        if (r_state == ST_MUL) begin
            r_plo <= PLO_W'(i_gain) * PLO_W'(r_diff[LO_W-1:0]);
            r_phi <= PHI_W'($signed(r_diff[DW-1:LO_W])) * PHI_W'($signed({1'b0, i_gain}));
        end
        if (r_state == ST_SUM) begin
            r_prod <= w_prod;
        end
    end

endmodule

/* sv/crpt_sqrt.sv */
module crpt_sqrt #(
    parameter int SB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2*SB-1:0] i_rad,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [SB-1:0]   o_root
);
    localparam int RW    = 2 * SB;
    localparam int REM_W = SB + 2;
    localparam int TW    = SB + 4;
    localparam int CNT_W = $clog2(SB);

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_RUN  = 2'd1;
    localparam logic [1:0] SQ_DONE = 2'd2;

    logic [1:0]       r_state;
    logic [RW-1:0]    r_rad;
    logic [REM_W-1:0] r_rem;
    logic [SB-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic [SB-1:0]    r_out;
    logic             r_out_valid;
    logic [TW-1:0]    w_rem_t;
    logic [TW-1:0]    w_trial;
    logic [TW-1:0]    w_rem_sub;
    logic             w_ge;
    logic             w_move;

    assign o_ready = (r_state == SQ_IDLE);
    assign o_empty = !r_out_valid;
    assign o_root  = r_out;

    // One root bit per cycle: bring down two radicand bits, try 4*root + 1.
    assign w_rem_t   = {r_rem, r_rad[RW-1:RW-2]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_ge      = (w_rem_t >= w_trial);
    assign w_rem_sub = w_rem_t - w_trial;
    assign w_move    = (r_state == SQ_DONE) && (!r_out_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                SQ_IDLE: begin
                    if (i_valid) begin
                        r_state <= SQ_RUN;
                    end
                end
                SQ_RUN: begin
                    if (r_cnt == '0) begin
                        r_state <= SQ_DONE;
                    end
                end
                SQ_DONE: begin
                    if (w_move) begin
                        r_state <= SQ_IDLE;
                    end
                end
                default: r_state <= SQ_IDLE;
            endcase
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SQ_IDLE && i_valid) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(SB - 1);
        end else if (r_state == SQ_RUN) begin
            r_rad  <= {r_rad[RW-3:0], 2'b00};
            r_rem  <= w_ge ? w_rem_sub[REM_W-1:0] : w_rem_t[REM_W-1:0];
            r_root <= {r_root[SB-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
        end
        if (w_move) begin
            r_out <= r_root;
        end
    end

endmodule

/* sv/complex_rms_power_tracker_unit.sv */
// Running RMS level of a complex sample stream. Each sample pushed in (I and Q, signed)
// yields one result: the floor square root of the integer part of a single-pole
// average of I*I + Q*Q, kept with 16 fraction bits and updated as
// avg += floor(gain * (power - avg) / 2^GAIN_FRAC_BITS). The gain register at byte
// address 0 is unsigned with GAIN_FRAC_BITS fraction bits; values above 1.0 saturate,
// and every write clears the average. Write it only while no sample is in flight.
// Samples are squared in the input stage and wait in a four-entry queue; the average
// update steps through its difference, multiply, sum and update states, and the
// bit-serial square root then finds one root bit per cycle. That square root unit is
// the slowest stage and sets the sustained sample rate; the averager can take the next
// sample while a root is still being worked out.
module complex_rms_power_tracker_unit #(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  crpt_pkg::t_paddr             paddr,
    input  crpt_pkg::t_pdata             pwdata,
    output crpt_pkg::t_pdata             prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_im,
    output logic                         empty,
    input  logic                         pop,
    output logic [SAMPLE_BITS-1:0]       o_rms_level
);
    import crpt_pkg::*;

    localparam int PW = 2 * SAMPLE_BITS;
    localparam int GW = GAIN_FRAC_BITS + 1;
    localparam logic [GW-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [GW-1:0] GAIN_RST = GW'(GAIN_RESET);

    logic [GW-1:0] r_gain;
    logic [GW-1:0] n_gain;
    logic [GW-1:0] w_wr_val;
    logic          w_sel_gain;
    logic          w_cfg_wr;
    logic          w_pow_valid;
    logic          w_pow_ready;
    logic [PW-1:0] w_pow;
    logic          w_q_valid;
    logic          w_q_ready;
    logic [PW-1:0] w_q_data;
    logic          w_hand_valid;
    logic          w_hand_ready;
    logic [PW-1:0] w_hand_data;

    // Register port.
    assign pready     = 1'b1;
    assign w_sel_gain = (paddr[PADDR_W-1:REG_IDX_LSB] == REG_SMOOTHING_GAIN);
    assign w_cfg_wr   = psel && penable && pwrite && pready && w_sel_gain;
    assign w_wr_val   = pwdata[GW-1:0];
    assign n_gain     = (w_wr_val > GAIN_ONE) ? GAIN_ONE : w_wr_val;
    assign prdata     = w_sel_gain ? PDATA_W'(r_gain) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
        end else if (w_cfg_wr) begin
            r_gain <= n_gain;
        end
    end

    crpt_front #(
        .SB (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_re        (i_sample_re),
        .i_im        (i_sample_im),
        .o_pow_valid (w_pow_valid),
        .i_pow_ready (w_pow_ready),
        .o_pow       (w_pow)
    );

    crpt_queue #(
        .W     (PW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_pow_valid),
        .o_wr_ready (w_pow_ready),
        .i_wr_data  (w_pow),
        .o_rd_valid (w_q_valid),
        .i_rd_ready (w_q_ready),
        .o_rd_data  (w_q_data)
    );

    crpt_avg #(
        .SB (SAMPLE_BITS),
        .G  (GAIN_FRAC_BITS)
    ) u_avg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_cfg_wr),
        .i_gain       (r_gain),
        .i_pow_valid  (w_q_valid),
        .o_pow_ready  (w_q_ready),
        .i_pow        (w_q_data),
        .o_hand_valid (w_hand_valid),
        .i_hand_ready (w_hand_ready),
        .o_hand_data  (w_hand_data)
    );

    crpt_sqrt #(
        .SB (SAMPLE_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_hand_valid),
        .o_ready (w_hand_ready),
        .i_rad   (w_hand_data),
        .o_empty (empty),
        .i_pop   (pop),
        .o_root  (o_rms_level)
    );

`ifndef SYNTHESIS
    a_gain_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= GAIN_ONE)
        else $error("Smoothing gain holds a value above one.");

    a_hand_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hand_valid && w_hand_ready) |=> !w_hand_valid)
        else $error("Averaged power offered again after its transaction.");

    a_sqrt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hand_valid && w_hand_ready) |=> !w_hand_ready)
        else $error("Square root unit still ready after taking a radicand.");
`endif

endmodule

/* dv/tb_complex_rms_power_tracker_unit.sv */
`timescale 1ns / 100ps

module tb_complex_rms_power_tracker_unit;
    import crpt_pkg::*;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_COUNT    = 10;

    // Byte address of the smoothing gain register.
    localparam t_paddr GAIN_ADDR = t_paddr'(REG_SMOOTHING_GAIN) << REG_IDX_LSB;

    // Byte address of the first index past the register map.
    localparam t_paddr UNMAPPED_ADDR = t_paddr'(1 << REG_IDX_LSB);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    class rms_scoreboard;
        longint unsigned gain;
        longint unsigned running_power;
        logic [SAMPLE_BITS-1:0] expected_levels[$];
        int unsigned errors;

        function new();
            gain = GAIN_RESET;
            running_power = 0;
            errors = 0;
        endfunction

        function logic [SAMPLE_BITS-1:0] floor_sqrt(longint unsigned x);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= x) begin
                    root = trial;
                end
            end
            return root[SAMPLE_BITS-1:0];
        endfunction

        function void write_reg(t_paddr addr, t_pdata data);
            longint unsigned g;
            if (addr[PADDR_W-1:REG_IDX_LSB] != REG_SMOOTHING_GAIN) begin
                return;
            end
            g = 64'(data[GAIN_FRAC_BITS:0]);
            if (g > (64'd1 << GAIN_FRAC_BITS)) begin
                g = 64'd1 << GAIN_FRAC_BITS;
            end
            gain = g;
            running_power = 0;
        endfunction

        function void note_sample(logic signed [SAMPLE_BITS-1:0] re,
                                  logic signed [SAMPLE_BITS-1:0] im);
            longint signed re_l;
            longint signed im_l;
            longint unsigned power;
            longint unsigned acc;
            re_l = 64'(re);
            im_l = 64'(im);
            power = longint'(re_l * re_l) + longint'(im_l * im_l);
            acc = ((64'd1 << GAIN_FRAC_BITS) - gain) * running_power
                + gain * (power << AVG_FRAC_BITS);
            running_power = (acc >> GAIN_FRAC_BITS) & 64'hFFFF_FFFF_FFFF;
            expected_levels.push_back(floor_sqrt(running_power >> AVG_FRAC_BITS));
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_level(logic [SAMPLE_BITS-1:0] got);
            logic [SAMPLE_BITS-1:0] want;
            if (expected_levels.size() == 0) begin
                report($sformatf("unexpected result: rms_level %0d", got));
                return;
            end
            want = expected_levels.pop_front();
            if (got !== want) begin
                report($sformatf("rms_level mismatch: expected %0d, got %0d", want, got));
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    t_paddr                        paddr;
    t_pdata                        pwdata;
    t_pdata                        prdata;
    logic                          pready;
    logic                          push;
    logic                          full;
    logic signed [SAMPLE_BITS-1:0] i_sample_re;
    logic signed [SAMPLE_BITS-1:0] i_sample_im;
    logic                          empty;
    logic                          pop;
    logic [SAMPLE_BITS-1:0]        o_rms_level;

    rms_scoreboard sb = new();
    bit push_throttle;
    bit pop_throttle;
    int unsigned pop_stall;

    complex_rms_power_tracker_unit #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .i_sample_re (i_sample_re),
        .i_sample_im (i_sample_im),
        .empty       (empty),
        .pop         (pop),
        .o_rms_level (o_rms_level)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        int unsigned r;
        logic signed [SAMPLE_BITS-1:0] v;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                v = SAMPLE_MIN;
            end
            1: begin
                v = SAMPLE_MAX;
            end
            2: begin
                v = '0;
            end
            3: begin
                v = SAMPLE_BITS'($urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            default: begin
                v = SAMPLE_BITS'($urandom());
            end
        endcase
        return v;
    endfunction

    // Result side: pop is driven at the falling edge, results are taken at the rising edge.
    initial begin
        pop = 1'b0;
        pop_stall = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                sb.check_level(o_rms_level);
                if (pop_throttle) begin
                    pop_stall = pick_gap();
                end
            end
            @(negedge i_clk);
            if (pop_stall > 0) begin
                pop = 1'b0;
                pop_stall--;
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] re,
                               logic signed [SAMPLE_BITS-1:0] im);
        int unsigned gap;
        gap = push_throttle ? pick_gap() : 0;
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_sample_re = re;
        i_sample_im = im;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        sb.note_sample(re, im);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (sb.expected_levels.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic apb_write(t_paddr addr, t_pdata data);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        sb.write_reg(addr, data);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial begin
        t_pdata gain_word;
        int unsigned item_count;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        i_sample_re = '0;
        i_sample_im = '0;
        push_throttle = 1'b0;
        pop_throttle = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, first at the reset gain.
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);
        send_sample('0, '0);

        // Gain of one: the level follows each sample's magnitude.
        apb_write(GAIN_ADDR, 32'h0001_0000);
        send_sample('0, '0);
        send_sample(16'sd1, '0);
        send_sample('0, -16'sd1);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sh5555, 16'shAAAA);
        send_sample(16'shAAAA, 16'sh5555);
        send_sample(SAMPLE_MAX, '0);

        // Gains above one saturate.
        apb_write(GAIN_ADDR, 32'h0001_FFFF);
        send_sample(SAMPLE_MIN, '0);
        send_sample(16'sd3, 16'sd4);

        // Zero gain holds the cleared average.
        apb_write(GAIN_ADDR, 32'h0000_0000);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MAX);

        // A write past the register map neither changes the gain nor clears the average.
        apb_write(GAIN_ADDR, 32'h0000_0001);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);
        apb_write(UNMAPPED_ADDR, 32'h0001_0000);
        send_sample(SAMPLE_MIN, SAMPLE_MIN);

        // Bits above the gain field are dropped.
        apb_write(GAIN_ADDR, 32'hFFFE_1000);
        send_sample(SAMPLE_MAX, SAMPLE_MIN);
        send_sample(16'sd100, -16'sd100);

        // Random part: one gain setting per phase.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: gain_word = 32'h0001_0000;
                1: gain_word = 32'h0000_0001;
                2: gain_word = 32'h0000_0000;
                3: gain_word = 32'h0000_FFFF;
                4: gain_word = $urandom_range(2, 65534);
                5: gain_word = $urandom();
                6: gain_word = 32'h0001_FFFF;
                7: gain_word = GAIN_RESET;
                8: gain_word = $urandom_range(256, 4096);
                default: gain_word = $urandom_range(30000, 65536);
            endcase
            apb_write(GAIN_ADDR, gain_word);
            push_throttle = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
            pop_throttle = (phase % 4 != 2) && ($urandom_range(0, 3) != 0);
            item_count = (phase == 2) ? 40 : 120;
            for (int n = 0; n < item_count; n++) begin
                // Now and then the sender holds off until every result is back.
                if (n == 60 && (phase % 3 == 0)) begin
                    wait_drained();
                end
                send_sample(pick_sample(), pick_sample());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_levels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
